// ===== design/cc20_pkg.sv =====
package cc20_pkg;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam int DOUBLE_ROUNDS = 10;
	// two rounds per double round, two half quarter rounds per round
	localparam int ROUND_STEPS = 4 * DOUBLE_ROUNDS;
	localparam int STEP_W = $clog2(ROUND_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FEED,
		ST_EMIT
	} cc20_state_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0] nonce_lo;
		logic [31:0] nonce_hi;
		logic [31:0] counter;
	} cc20_cfg_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic round;
		logic second;
		logic diag;
		logic feed;
		logic emit;
	} cc20_cmd_t;

	typedef struct packed {
		logic pos_zero;
		logic out_free;
	} cc20_sts_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} qr_t;

	// First half: rotations 16 and 12. Second half: rotations 8 and 7.
	function automatic qr_t half_qr(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d, input logic second);
		logic [31:0] a1;
		logic [31:0] dx;
		logic [31:0] d1;
		logic [31:0] c1;
		logic [31:0] bx;
		logic [31:0] b1;
		qr_t r;
		a1 = a + b;
		dx = d ^ a1;
		d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
		c1 = c + d1;
		bx = b ^ c1;
		b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
		r.a = a1;
		r.b = b1;
		r.c = c1;
		r.d = d1;
		return r;
	endfunction

endpackage

// ===== design/cc20_ctrl.sv =====
module cc20_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cc20_pkg::cc20_sts_t  sts,
	output cc20_pkg::cc20_cmd_t  cmd
);
	import cc20_pkg::*;

	cc20_state_t state_q;
	cc20_state_t state_nxt;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_LOAD) begin
			step_q <= '0;
		end else if (state_q == ST_ROUND && step_q != LAST_STEP) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		cmd.second = step_q[0];
		cmd.diag = step_q[1];
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt = sts.pos_zero ? ST_LOAD : ST_EMIT;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_nxt = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (step_q == LAST_STEP) begin
					state_nxt = ST_FEED;
				end
			end
			ST_FEED: begin
				cmd.feed = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> step_q <= LAST_STEP)
		else $error("round step past last step");

	a_feed_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FEED |=> state_q == ST_EMIT)
		else $error("feed-forward not followed by emit");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == ST_LOAD || state_q == ST_EMIT)
		else $error("accepted word did not start work");

	a_round_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> state_q == ST_ROUND && step_q == '0)
		else $error("rounds did not start at step zero");

endmodule

// ===== design/cc20_core.sv =====
module cc20_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cc20_pkg::cc20_cfg_t  cfg,
	input  cc20_pkg::cc20_cmd_t  cmd,
	output cc20_pkg::cc20_sts_t  sts,
	input  logic [7:0]           data_in,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           data_out,
	output logic                 last_out
);
	import cc20_pkg::*;

	logic [7:0]  in_data_q;
	logic        in_last_q;
	logic [31:0] work_q [16];
	logic [31:0] work_nxt [16];
	logic [31:0] ks_q [16];
	logic [31:0] init_w [16];
	logic [5:0]  pos_q;
	logic [31:0] blocks_q;
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        out_last_q;
	logic [31:0] ks_word;

	// block input: constants, key, counter, nonce
	always_comb begin
		init_w[0] = SIGMA0;
		init_w[1] = SIGMA1;
		init_w[2] = SIGMA2;
		init_w[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_w[4 + 2 * i] = cfg.key[i][31:0];
			init_w[5 + 2 * i] = cfg.key[i][63:32];
		end
		init_w[12] = cfg.counter + blocks_q;
		init_w[13] = cfg.nonce_lo[31:0];
		init_w[14] = cfg.nonce_lo[63:32];
		init_w[15] = cfg.nonce_hi;
	end

	// four lanes, each half a quarter round per step; diagonal rounds rotate the lanes
	always_comb begin
		logic [3:0] ia;
		logic [3:0] ib;
		logic [3:0] ic;
		logic [3:0] id;
		qr_t r;
		for (int i = 0; i < 16; i++) begin
			work_nxt[i] = work_q[i];
		end
		for (int j = 0; j < 4; j++) begin
			ia = 4'(j);
			ib = cmd.diag ? 4'(4 + ((j + 1) & 3)) : 4'(4 + j);
			ic = cmd.diag ? 4'(8 + ((j + 2) & 3)) : 4'(8 + j);
			id = cmd.diag ? 4'(12 + ((j + 3) & 3)) : 4'(12 + j);
			r = half_qr(work_q[ia], work_q[ib], work_q[ic], work_q[id], cmd.second);
			work_nxt[ia] = r.a;
			work_nxt[ib] = r.b;
			work_nxt[ic] = r.c;
			work_nxt[id] = r.d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_data_q <= data_in;
			in_last_q <= last_byte;
		end
		if (cmd.load) begin
			work_q <= init_w;
		end else if (cmd.round) begin
			work_q <= work_nxt;
		end
		if (cmd.feed) begin
			for (int i = 0; i < 16; i++) begin
				ks_q[i] <= work_q[i] + init_w[i];
			end
		end
	end

	assign ks_word = ks_q[pos_q[5:2]];

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= in_data_q ^ ks_word[{pos_q[1:0], 3'b000} +: 8];
			out_last_q <= in_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			blocks_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.feed) begin
				blocks_q <= blocks_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (in_last_q) begin
					pos_q <= '0;
					blocks_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.pos_zero = (pos_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign data_out = out_data_q;
	assign last_out = out_last_q;

endmodule

// ===== design/chacha20_stream_cipher_unit.sv =====
// ChaCha20 (RFC 8439) byte-stream cipher: each input word is a data byte that
// leaves XORed with the next keystream byte, with its last-byte flag copied.
// Key, nonce and initial block counter are written over the APB port, 64-bit
// registers at byte address 8*i (key bytes 0-7, 8-15, 16-23, 24-31, nonce
// bytes 0-7, nonce bytes 8-11, initial counter); write them only while idle.
// A byte at keystream position 0 starts a new 64-byte block, and the next word
// is not accepted until that block is through: a load, 40 round steps of the
// shared quarter-round unit (four lanes, half a quarter round per step), a
// feed-forward and the output of the byte. Every other byte goes straight to
// the output. The result sits in an output register, so a stalled result does not
// block the next accept. After a byte flagged last, the next byte restarts at
// position 0 with the initial counter; the block counter wraps at 2^32.
module chacha20_stream_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_out,
	output logic        last_out
);
	import cc20_pkg::*;

	localparam logic [2:0] REG_KEY0    = 3'd0;
	localparam logic [2:0] REG_KEY1    = 3'd1;
	localparam logic [2:0] REG_KEY2    = 3'd2;
	localparam logic [2:0] REG_KEY3    = 3'd3;
	localparam logic [2:0] REG_NONCE_L = 3'd4;
	localparam logic [2:0] REG_NONCE_H = 3'd5;
	localparam logic [2:0] REG_COUNTER = 3'd6;

	cc20_cfg_t cfg_q;
	cc20_cmd_t cmd;
	cc20_sts_t sts;
	logic      wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en = psel && penable && pwrite && pready;

	// register file; writes to the unused slot drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_KEY0:    cfg_q.key[0] <= pwdata;
				REG_KEY1:    cfg_q.key[1] <= pwdata;
				REG_KEY2:    cfg_q.key[2] <= pwdata;
				REG_KEY3:    cfg_q.key[3] <= pwdata;
				REG_NONCE_L: cfg_q.nonce_lo <= pwdata;
				REG_NONCE_H: cfg_q.nonce_hi <= pwdata[31:0];
				REG_COUNTER: cfg_q.counter <= pwdata[31:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KEY0:    prdata = cfg_q.key[0];
			REG_KEY1:    prdata = cfg_q.key[1];
			REG_KEY2:    prdata = cfg_q.key[2];
			REG_KEY3:    prdata = cfg_q.key[3];
			REG_NONCE_L: prdata = cfg_q.nonce_lo;
			REG_NONCE_H: prdata = {32'd0, cfg_q.nonce_hi};
			REG_COUNTER: prdata = {32'd0, cfg_q.counter};
			default:     prdata = '0;
		endcase
	end

	// sequence the block: accept, load, rounds, feed-forward, emit
	cc20_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// round state, keystream block, byte position and output register
	cc20_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.data_in   (data_in),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.last_out  (last_out)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	// Keystream constants ("expand 32-byte k") and block geometry
	localparam logic [31:0] SIGMA_W0 = 32'h61707865;
	localparam logic [31:0] SIGMA_W1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_W2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_W3 = 32'h6b206574;
	localparam int DOUBLE_ROUNDS = 10;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 4;
	localparam int PHASES         = 5;
	localparam int WORDS_PER_PHASE = 140;
	// idle time after the last expected result, before the configuration changes
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 60;
	localparam int HOLD_AFTER     = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int CYCLE_LIMIT    = 400000;

	typedef enum logic [2:0] {
		REG_KEY_0_7,
		REG_KEY_8_15,
		REG_KEY_16_23,
		REG_KEY_24_31,
		REG_NONCE_0_7,
		REG_NONCE_8_11,
		REG_INIT_CTR,
		REG_UNMAPPED
	} cc_reg_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_byte_t;

	// pinned rows carry the expected result, read straight off the all-zero test vector
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       pinned;
		logic [7:0] want;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_in = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_out;
	logic        last_out;

	chacha20_stream_cipher_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_in   (data_in),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.last_out  (last_out)
	);

	always #HALF_PERIOD clk = ~clk;

	// Cipher state as the block should hold it: configuration, the current
	// keystream block, the byte position in it and the blocks made so far in
	// the running message.
	logic [3:0][63:0]  cfg_key = '0;
	logic [63:0]       cfg_nonce_lo = '0;
	logic [31:0]       cfg_nonce_hi = '0;
	logic [31:0]       cfg_ctr = '0;
	logic [15:0][31:0] ks_words = '0;
	logic [5:0]        ks_pos = '0;
	logic [31:0]       blocks_in_msg = '0;

	cipher_byte_t pending_cipher_bytes[$];
	int errors = 0;
	int words_accepted = 0;
	int burst_left = 0;
	int msg_left = 0;
	int cycles = 0;

	// Bit walk after reset (all-zero key, nonce, counter): the first keystream
	// bytes are 76 b8 e0 ad a0 f1 3d, so pinned rows read their result off that.
	directed_row_t directed_rows [22] = '{
		'{8'h00, 1'b0, 1'b1, 8'h76},
		'{8'hFF, 1'b0, 1'b1, 8'h47},
		'{8'h00, 1'b0, 1'b1, 8'hE0},
		'{8'h00, 1'b1, 1'b1, 8'hAD},
		// one-byte messages: each restarts at position 0 with the initial counter
		'{8'h00, 1'b1, 1'b1, 8'h76},
		'{8'h80, 1'b1, 1'b1, 8'hF6},
		'{8'h01, 1'b0, 1'b1, 8'h77},
		'{8'h02, 1'b0, 1'b1, 8'hBA},
		'{8'h04, 1'b0, 1'b1, 8'hE4},
		'{8'h08, 1'b0, 1'b1, 8'hA5},
		'{8'h10, 1'b0, 1'b1, 8'hB0},
		'{8'h20, 1'b0, 1'b1, 8'hD1},
		'{8'h40, 1'b0, 1'b1, 8'h7D},
		'{8'h55, 1'b0, 1'b0, 8'h00},
		'{8'hAA, 1'b0, 1'b0, 8'h00},
		'{8'h0F, 1'b0, 1'b0, 8'h00},
		'{8'hF0, 1'b0, 1'b0, 8'h00},
		'{8'hFE, 1'b0, 1'b0, 8'h00},
		'{8'h7F, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 1'b0, 8'h00},
		'{8'hC3, 1'b1, 1'b0, 8'h00}
	};

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Build one keystream block for the given block counter: 20 rounds on a
	// copy of the initial state, then add the initial state back word by word.
	function automatic void refill_keystream(input logic [31:0] blk_ctr);
		logic [15:0][31:0] init_w;
		logic [15:0][31:0] w;
		int r;
		int q;
		int k;
		int a;
		int b;
		int c;
		int d;
		init_w[0] = SIGMA_W0;
		init_w[1] = SIGMA_W1;
		init_w[2] = SIGMA_W2;
		init_w[3] = SIGMA_W3;
		for (k = 0; k < 4; k++) begin
			init_w[4 + 2 * k] = cfg_key[k][31:0];
			init_w[5 + 2 * k] = cfg_key[k][63:32];
		end
		init_w[12] = blk_ctr;
		init_w[13] = cfg_nonce_lo[31:0];
		init_w[14] = cfg_nonce_lo[63:32];
		init_w[15] = cfg_nonce_hi;
		w = init_w;
		for (r = 0; r < DOUBLE_ROUNDS; r++) begin
			// quarter rounds 0-3 mix the columns, 4-7 the diagonals
			for (q = 0; q < 8; q++) begin
				a = q % 4;
				b = 4 + ((q < 4) ? a : (a + 1) % 4);
				c = 8 + ((q < 4) ? a : (a + 2) % 4);
				d = 12 + ((q < 4) ? a : (a + 3) % 4);
				w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
				w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
				w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
				w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
			end
		end
		for (k = 0; k < 16; k++)
			ks_words[k] = w[k] + init_w[k];
	endfunction

	// Advance the cipher state by one accepted byte and return its result.
	function automatic cipher_byte_t predict_cipher_byte(input logic [7:0] d, input logic l);
		cipher_byte_t res;
		if (ks_pos == 6'd0) begin
			// the block counter wraps modulo 2^32, nonce untouched
			refill_keystream(cfg_ctr + blocks_in_msg);
			blocks_in_msg = blocks_in_msg + 32'd1;
		end
		res.data = d ^ ks_words[ks_pos[5:2]][8 * ks_pos[1:0] +: 8];
		res.last = l;
		if (l) begin
			ks_pos = '0;
			blocks_in_msg = '0;
		end else begin
			ks_pos = ks_pos + 6'd1;
		end
		return res;
	endfunction

	// One APB write: setup phase, access phase, then idle with psel low so that
	// back-to-back writes never touch psel twice in one step.
	task automatic apb_write(input cc_reg_t r, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_KEY_0_7, REG_KEY_8_15, REG_KEY_16_23, REG_KEY_24_31: cfg_key[r] = val;
			REG_NONCE_0_7: cfg_nonce_lo = val;
			REG_NONCE_8_11: cfg_nonce_hi = val[31:0];
			REG_INIT_CTR: cfg_ctr = val[31:0];
			default: ; // unmapped address: drop the write
		endcase
		@(posedge clk);
	endtask

	// Offer one word and hold it until accepted. Bursts of random length
	// alternate with random gaps; now and then a long burst runs with no gap.
	task automatic offer_byte(input logic [7:0] d, input logic l, input logic pinned,
			input logic [7:0] want);
		cipher_byte_t exp_word;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
				: $urandom_range(8, 1);
			in_valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_in <= d;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		exp_word = predict_cipher_byte(d, l);
		if (pinned)
			exp_word.data = want;
		pending_cipher_bytes.push_back(exp_word);
		words_accepted++;
	endtask

	// Random messages: mostly short, some crossing one or two block borders.
	// A message left open at the end of a phase carries on into the next one.
	task automatic offer_random_words(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			if (msg_left == 0) begin
				case ($urandom_range(9, 0))
					0, 1, 2, 3, 4: msg_left = $urandom_range(16, 1);
					5, 6, 7: msg_left = $urandom_range(80, 17);
					default: msg_left = $urandom_range(140, 60);
				endcase
			end
			msg_left--;
			offer_byte(8'($urandom), msg_left == 0, 1'b0, 8'h00);
		end
	endtask

	// Drop valid, wait for every expected word, then let the block settle.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_cipher_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int row;
		int p;
		int i;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on reset configuration
		for (row = 0; row < $size(directed_rows); row++)
			offer_byte(directed_rows[row].data, directed_rows[row].last,
				directed_rows[row].pinned, directed_rows[row].want);

		// Random part: rewrite configuration between phases. A phase may end
		// mid-message, so the held keystream block must outlive the new values.
		for (p = 0; p < PHASES; p++) begin
			wait_for_results();
			case (p)
				0: begin
					// all ones everywhere; counter at the top forces a wrap
					for (i = 0; i <= int'(REG_INIT_CTR); i++)
						apb_write(cc_reg_t'(i), '1);
				end
				1: begin
					apb_write(REG_KEY_0_7, 64'h0706050403020100);
					apb_write(REG_KEY_8_15, 64'h0f0e0d0c0b0a0908);
					apb_write(REG_KEY_16_23, 64'h1716151413121110);
					apb_write(REG_KEY_24_31, 64'h1f1e1d1c1b1a1918);
					apb_write(REG_NONCE_0_7, 64'h4a00000000000000);
					apb_write(REG_NONCE_8_11, 64'h0);
					apb_write(REG_INIT_CTR, 64'h1);
				end
				2: begin
					for (i = 0; i < int'(REG_INIT_CTR); i++)
						apb_write(cc_reg_t'(i), '0);
					apb_write(REG_INIT_CTR, 64'hFFFF_FFFF);
					// nothing sits at this address: the write must change nothing
					apb_write(REG_UNMAPPED, {$urandom, $urandom});
				end
				default: begin
					for (i = 0; i <= int'(REG_INIT_CTR); i++)
						if ($urandom_range(3, 0) != 0)
							apb_write(cc_reg_t'(i), {$urandom, $urandom});
					if (p == PHASES - 1)
						apb_write(REG_INIT_CTR, 64'hFFFF_FFFE);
				end
			endcase
			offer_random_words(WORDS_PER_PHASE);
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Receiver pacing: stretches of no stall, light and heavy random stall and
	// toggling, plus one long hold-off that fills the block and stalls its input.
	initial begin : rx_pacing
		int seg_left;
		int hold_left;
		bit hold_done;
		rx_mode_t seg_mode;
		seg_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		seg_mode = RX_FREE;
		forever begin
			@(posedge clk);
			if (!hold_done && words_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(40, 1);
					seg_mode = rx_mode_t'($urandom_range(3, 0));
				end
				seg_left--;
				case (seg_mode)
					RX_FREE: out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(9, 0) < 6);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// Compare each accepted result with the oldest expected word
	always @(posedge clk) begin : result_check
		cipher_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cipher_bytes.size() == 0) begin
				$error("unexpected word: data_out=%h last_out=%b", data_out, last_out);
				errors++;
			end else begin
				want = pending_cipher_bytes.pop_front();
				if (data_out !== want.data) begin
					$error("data_out: expected %h, got %h", want.data, data_out);
					errors++;
				end
				if (last_out !== want.last) begin
					$error("last_out: expected %b, got %b", want.last, last_out);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

// ===== chacha20_stream_cipher_unit.f =====
design/cc20_pkg.sv
design/cc20_ctrl.sv
design/cc20_core.sv
design/chacha20_stream_cipher_unit.sv
dv/testbench.sv
